// File: src/ptx_pkg.sv
// shared types, constants and vertex sequencing tables for the triangle expander
// no dependencies
`default_nettype none

package ptx_pkg;

	localparam int CW      = 16;
	localparam int TW      = 15;
	localparam int CORNERW = 48;
	localparam int COLORW  = 32;
	localparam int SLOTS   = 6;
	localparam int SLOTW   = 3;
	localparam int IDXW    = 4;
	localparam int IN_DW   = 240;
	localparam int OUT_DW  = 80;

	localparam logic [1:0] CMD_TRI  = 2'd0;
	localparam logic [1:0] CMD_BOX  = 2'd1;
	localparam logic [1:0] CMD_QUAD = 2'd2;
	localparam logic [1:0] CMD_LINE = 2'd3;

	typedef enum logic [1:0] {
		PAT_TRI,
		PAT_QUAD,
		PAT_AXIS,
		PAT_DIAG
	} pat_t;

	typedef struct packed {
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] x;
	} point_t;

	typedef struct packed {
		pat_t                   pat;
		point_t [SLOTS-1:0]     pts;
		logic   [COLORW-1:0]    color;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// saturating add of a coordinate and a signed addend one bit wider
	function automatic logic signed [CW-1:0] sat_add(
		input logic signed [CW-1:0] a,
		input logic signed [CW:0]   b
	);
		logic signed [CW+1:0] s;
		logic signed [CW-1:0] r;
		s = {a[CW-1], a[CW-1], a} + {b[CW], b};
		if (s[CW+1] == s[CW] && s[CW] == s[CW-1]) begin
			r = s[CW-1:0];
		end else if (s[CW+1]) begin
			r = {1'b1, {(CW-1){1'b0}}};
		end else begin
			r = {1'b0, {(CW-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [IDXW-1:0] last_idx(input pat_t pat);
		logic [IDXW-1:0] r;
		case (pat)
			PAT_TRI:  r = IDXW'(2);
			PAT_QUAD: r = IDXW'(5);
			PAT_AXIS: r = IDXW'(5);
			PAT_DIAG: r = IDXW'(11);
			default:  r = IDXW'(2);
		endcase
		return r;
	endfunction

	function automatic logic [SLOTW-1:0] vtx_slot(input pat_t pat, input logic [IDXW-1:0] idx);
		logic [SLOTW-1:0] r;
		r = '0;
		case (pat)
			PAT_TRI: begin
				r = idx[SLOTW-1:0];
			end
			PAT_QUAD: begin
				case (idx)
					4'd0, 4'd3: r = SLOTW'(0);
					4'd1:       r = SLOTW'(1);
					4'd2, 4'd4: r = SLOTW'(2);
					default:    r = SLOTW'(3);
				endcase
			end
			PAT_AXIS: begin
				case (idx)
					4'd0:       r = SLOTW'(0);
					4'd1, 4'd3: r = SLOTW'(1);
					4'd2, 4'd4: r = SLOTW'(2);
					default:    r = SLOTW'(3);
				endcase
			end
			PAT_DIAG: begin
				case (idx)
					4'd0, 4'd3, 4'd6, 4'd9: r = SLOTW'(0);
					4'd1:                   r = SLOTW'(1);
					4'd2, 4'd4:             r = SLOTW'(2);
					4'd5, 4'd7:             r = SLOTW'(3);
					4'd8, 4'd10:            r = SLOTW'(4);
					default:                r = SLOTW'(5);
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/ptx_front.sv
// front end: unpacks a primitive, does the saturating sums and builds a descriptor
// depends on ptx_pkg
`default_nettype none

module ptx_front (
	input  wire logic [1:0]                     cmd,
	input  wire logic [ptx_pkg::CORNERW-1:0]    corner_a,
	input  wire logic [ptx_pkg::CORNERW-1:0]    corner_b,
	input  wire logic [ptx_pkg::CORNERW-1:0]    corner_c,
	input  wire logic [ptx_pkg::CORNERW-1:0]    corner_d,
	input  wire logic [ptx_pkg::COLORW-1:0]     color,
	input  wire logic [ptx_pkg::TW-1:0]         thickness,
	output ptx_pkg::desc_t                      desc
);

	localparam int CW = ptx_pkg::CW;

	ptx_pkg::point_t pa, pb, pc, pd;
	logic signed [CW:0]   tt;
	logic signed [CW:0]   bx_w, by_w;
	logic signed [CW-1:0] xw, yh;
	logic signed [CW-1:0] ax1, ay1, ax2, ay2;
	logic signed [CW-1:0] dx1, dy1, dx2, dy2;
	logic signed [CW-1:0] dx1b, dy1b, dx2b, dy2b;
	logic                 axis;

	assign pa = ptx_pkg::point_t'(corner_a[3*CW-1:0]);
	assign pb = ptx_pkg::point_t'(corner_b[3*CW-1:0]);
	assign pc = ptx_pkg::point_t'(corner_c[3*CW-1:0]);
	assign pd = ptx_pkg::point_t'(corner_d[3*CW-1:0]);

	assign tt   = {{(CW+1-ptx_pkg::TW){1'b0}}, thickness};
	assign bx_w = {pb.x[CW-1], pb.x};
	assign by_w = {pb.y[CW-1], pb.y};

	// box corners
	assign xw = ptx_pkg::sat_add(pa.x, bx_w);
	assign yh = ptx_pkg::sat_add(pa.y, by_w);

	// axis-aligned line: the larger end grows
	assign axis = (pa.x == pb.x) || (pa.y == pb.y);
	assign ax1  = (pa.x > pb.x) ? ptx_pkg::sat_add(pa.x, tt) : pa.x;
	assign ax2  = (pa.x > pb.x) ? pb.x : ptx_pkg::sat_add(pb.x, tt);
	assign ay1  = (pa.y > pb.y) ? ptx_pkg::sat_add(pa.y, tt) : pa.y;
	assign ay2  = (pa.y > pb.y) ? pb.y : ptx_pkg::sat_add(pb.y, tt);

	// diagonal line: ends swapped in x and y only
	assign dx1  = (pa.x > pb.x) ? pb.x : pa.x;
	assign dy1  = (pa.x > pb.x) ? pb.y : pa.y;
	assign dx2  = (pa.x > pb.x) ? pa.x : pb.x;
	assign dy2  = (pa.x > pb.x) ? pa.y : pb.y;
	assign dx1b = ptx_pkg::sat_add(dx1, tt);
	assign dy1b = ptx_pkg::sat_add(dy1, tt);
	assign dx2b = ptx_pkg::sat_add(dx2, tt);
	assign dy2b = ptx_pkg::sat_add(dy2, tt);

	always_comb begin
		desc.color = color;
		desc.pat   = ptx_pkg::PAT_TRI;
		desc.pts   = '0;
		case (cmd)
			ptx_pkg::CMD_TRI: begin
				desc.pat    = ptx_pkg::PAT_TRI;
				desc.pts[0] = pa;
				desc.pts[1] = pb;
				desc.pts[2] = pc;
			end
			ptx_pkg::CMD_BOX: begin
				desc.pat    = ptx_pkg::PAT_QUAD;
				desc.pts[0] = '{z: pa.z, y: pa.y, x: pa.x};
				desc.pts[1] = '{z: pa.z, y: pa.y, x: xw};
				desc.pts[2] = '{z: pa.z, y: yh,   x: xw};
				desc.pts[3] = '{z: pa.z, y: yh,   x: pa.x};
			end
			ptx_pkg::CMD_QUAD: begin
				desc.pat    = ptx_pkg::PAT_QUAD;
				desc.pts[0] = pa;
				desc.pts[1] = pb;
				desc.pts[2] = pd;
				desc.pts[3] = pc;
			end
			default: begin
				if (axis) begin
					desc.pat    = ptx_pkg::PAT_AXIS;
					desc.pts[0] = '{z: pb.z, y: ay1, x: ax1};
					desc.pts[1] = '{z: pb.z, y: ay2, x: ax1};
					desc.pts[2] = '{z: pa.z, y: ay1, x: ax2};
					desc.pts[3] = '{z: pa.z, y: ay2, x: ax2};
				end else begin
					desc.pat    = ptx_pkg::PAT_DIAG;
					desc.pts[0] = '{z: pa.z, y: dy1, x: dx1};
					desc.pts[3] = '{z: pb.z, y: dy2b, x: dx2b};
					desc.pts[5] = '{z: pa.z, y: dy1b, x: dx1};
					if (dy1 > dy2) begin
						desc.pts[1] = '{z: pb.z, y: dy2,  x: dx2};
						desc.pts[2] = '{z: pb.z, y: dy2,  x: dx2b};
						desc.pts[4] = '{z: pa.z, y: dy1b, x: dx1b};
					end else begin
						desc.pts[1] = '{z: pa.z, y: dy1,  x: dx1b};
						desc.pts[2] = '{z: pb.z, y: dy2,  x: dx2b};
						desc.pts[4] = '{z: pb.z, y: dy2b, x: dx2};
					end
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/ptx_queue.sv
// two-entry descriptor queue between front and back
// depends on ptx_pkg
`default_nettype none

module ptx_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire ptx_pkg::desc_t      wr_desc,
	input  wire logic                pop,
	output ptx_pkg::desc_t           rd_desc,
	output ptx_pkg::q_status_t       status
);

	ptx_pkg::desc_t mem_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push, do_pop;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rd_desc      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_desc;
	end

endmodule

`default_nettype wire

// File: src/ptx_back.sv
// back end: steps through the vertices of the head descriptor into the output register
// depends on ptx_pkg
`default_nettype none

module ptx_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ptx_pkg::desc_t             desc,
	input  wire ptx_pkg::q_status_t         status,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output ptx_pkg::point_t                 out_pt,
	output logic [ptx_pkg::COLORW-1:0]      out_color,
	output logic                            out_last
);

	logic [ptx_pkg::IDXW-1:0]  idx_q;
	logic                      out_valid_q;
	ptx_pkg::point_t           pt_q;
	logic [ptx_pkg::COLORW-1:0] color_q;
	logic                      last_q;
	logic                      load, emit, at_last;
	logic [ptx_pkg::SLOTW-1:0] slot;

	assign load    = !out_valid_q || out_ready;
	assign emit    = load && !status.empty;
	assign at_last = (idx_q == ptx_pkg::last_idx(desc.pat));
	assign slot    = ptx_pkg::vtx_slot(desc.pat, idx_q);
	assign pop     = emit && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= !status.empty;
			if (emit) idx_q <= at_last ? '0 : idx_q + ptx_pkg::IDXW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pt_q    <= desc.pts[slot];
			color_q <= desc.color;
			last_q  <= at_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pt    = pt_q;
	assign out_color = color_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

// File: src/primitive_triangle_expander_core.sv
// top level of the triangle expander: front end, descriptor queue and vertex sequencer
// depends on ptx_pkg, ptx_front, ptx_queue, ptx_back
// an input transaction is written into the descriptor queue; its first vertex then goes
// through the output register. throughput: one vertex per cycle while m_axis_tready is
// high and a descriptor is queued; a primitive gives 3, 6 or 12 vertices
// reset: arst_n clears queue pointers, vertex counter and output valid; data is not reset
`default_nettype none

module primitive_triangle_expander_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// corner_a, corner_b, corner_c, corner_d, color, thickness, zero pad
	input  wire logic [ptx_pkg::IN_DW-1:0]   s_axis_tdata,
	// cmd
	input  wire logic [1:0]                  s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// pos_x, pos_y, pos_z, vertex_color
	output logic [ptx_pkg::OUT_DW-1:0]       m_axis_tdata,
	output logic                             m_axis_tlast
);

	localparam int CN = ptx_pkg::CORNERW;

	ptx_pkg::desc_t     f_desc, q_desc;
	ptx_pkg::q_status_t q_status;
	logic               q_pop;
	ptx_pkg::point_t    o_pt;
	logic [ptx_pkg::COLORW-1:0] o_color;

	ptx_front u_front (
		.cmd       (s_axis_tuser),
		.corner_a  (s_axis_tdata[CN-1:0]),
		.corner_b  (s_axis_tdata[2*CN-1:CN]),
		.corner_c  (s_axis_tdata[3*CN-1:2*CN]),
		.corner_d  (s_axis_tdata[4*CN-1:3*CN]),
		.color     (s_axis_tdata[4*CN+ptx_pkg::COLORW-1:4*CN]),
		.thickness (s_axis_tdata[4*CN+ptx_pkg::COLORW+ptx_pkg::TW-1:4*CN+ptx_pkg::COLORW]),
		.desc      (f_desc)
	);

	ptx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (s_axis_tvalid),
		.wr_desc (f_desc),
		.pop     (q_pop),
		.rd_desc (q_desc),
		.status  (q_status)
	);

	ptx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc      (q_desc),
		.status    (q_status),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pt    (o_pt),
		.out_color (o_color),
		.out_last  (m_axis_tlast)
	);

	assign s_axis_tready = !q_status.full;
	assign m_axis_tdata  = {o_color, o_pt.z, o_pt.y, o_pt.x};

endmodule

`default_nettype wire
